[design/cwpd_pkg.sv]
// shared types, constants and codes for the click wheel packet decoder
package cwpd_pkg;

	localparam logic [31:0] PKT_MASK    = 32'h8000_00ff;
	localparam logic [31:0] PKT_BUTTONS = 32'h8000_001a;
	localparam logic [31:0] PKT_BENIGN  = 32'h8000_003a;
	localparam logic [31:0] WORD_IDLE   = 32'hffff_ffff;
	localparam int unsigned TOUCH_BIT   = 30;

	localparam int unsigned POS_W    = 7;
	localparam int unsigned STEPS_W  = 7;
	localparam int unsigned THR_W    = 6;
	localparam int unsigned BTN_W    = 5;
	localparam int unsigned DELTA_W  = 7;
	localparam int unsigned CFG_W    = 7;
	localparam int unsigned IN_W     = 40;
	localparam int unsigned OUT_W    = 32;

	localparam logic [STEPS_W-1:0] STEPS_RESET = 7'd96;
	localparam logic [THR_W-1:0]   THR_RESET   = 6'd2;

	// configuration register indexes
	localparam logic REG_WHEEL_STEPS    = 1'b0;
	localparam logic REG_MOVE_THRESHOLD = 1'b1;

	// rotation codes
	localparam logic [1:0] ROT_NONE = 2'd0;
	localparam logic [1:0] ROT_CW   = 2'd1;
	localparam logic [1:0] ROT_CCW  = 2'd2;

	typedef struct packed {
		logic        hold_switch_low;
		logic        data_ready;
		logic [31:0] raw_word;
	} poll_t;

	typedef struct packed {
		logic [POS_W-1:0] last_position;
		logic             last_position_known;
		logic [BTN_W-1:0] held_buttons;
	} wheel_state_t;

	typedef struct packed {
		logic                      packet_valid;
		logic                      select_pressed;
		logic                      right_pressed;
		logic                      left_pressed;
		logic                      play_pressed;
		logic                      menu_pressed;
		logic                      hold_active;
		logic                      finger_on;
		logic [POS_W-1:0]          touch_pos;
		logic signed [DELTA_W-1:0] move_delta;
		logic [1:0]                rotation;
		logic                      rearm_request;
	} result_t;

endpackage

[design/cwpd_decode.sv]
// decode of one poll word against the wheel state
module cwpd_decode (
	input  cwpd_pkg::poll_t                poll,
	input  cwpd_pkg::wheel_state_t         state,
	input  logic [cwpd_pkg::STEPS_W-1:0]   wheel_steps,
	input  logic [cwpd_pkg::THR_W-1:0]     move_threshold,
	output cwpd_pkg::result_t              result,
	output cwpd_pkg::wheel_state_t         next_state
);
	import cwpd_pkg::*;

	logic [POS_W-1:0]   pos;
	logic signed [9:0]  steps_w;
	logic signed [9:0]  half_w;
	logic signed [9:0]  thr_w;
	logic signed [9:0]  d_raw;
	logic signed [9:0]  d_lo;
	logic signed [9:0]  d_wrap;
	logic signed [9:0]  d_sat;
	logic [BTN_W-1:0]   buttons;
	logic               is_buttons;
	logic               is_benign;

	assign pos        = poll.raw_word[22:16];
	assign steps_w    = $signed({3'b000, wheel_steps});
	assign half_w     = $signed({4'b0000, wheel_steps[STEPS_W-1:1]});
	assign thr_w      = (move_threshold == '0) ? 10'sd1 : $signed({4'b0000, move_threshold});
	assign d_raw      = $signed({3'b000, pos}) - $signed({3'b000, state.last_position});
	// single wrap correction each way, lower check first
	assign d_lo       = (d_raw < -half_w) ? d_raw + steps_w : d_raw;
	assign d_wrap     = (d_lo > half_w) ? d_lo - steps_w : d_lo;
	assign d_sat      = (d_wrap > 10'sd63) ? 10'sd63 :
	                    (d_wrap < -10'sd64) ? -10'sd64 : d_wrap;
	assign is_buttons = (poll.raw_word & PKT_MASK) == PKT_BUTTONS;
	assign is_benign  = ((poll.raw_word & PKT_MASK) == PKT_BENIGN)
	                    || (poll.raw_word == WORD_IDLE);
	assign buttons    = (poll.data_ready && is_buttons) ? poll.raw_word[12:8]
	                                                     : state.held_buttons;

	always_comb begin
		result                = '0;
		next_state            = state;
		result.hold_active    = ~poll.hold_switch_low;
		result.select_pressed = buttons[0];
		result.right_pressed  = buttons[1];
		result.left_pressed   = buttons[2];
		result.play_pressed   = buttons[3];
		result.menu_pressed   = buttons[4];
		if (poll.data_ready) begin
			if (is_buttons) begin
				next_state.held_buttons = buttons;
				result.packet_valid     = 1'b1;
				if (poll.raw_word[TOUCH_BIT]) begin
					result.finger_on = 1'b1;
					result.touch_pos = pos;
					if (state.last_position_known) begin
						if (d_sat >= thr_w) begin
							result.move_delta = d_sat[DELTA_W-1:0];
							result.rotation   = ROT_CW;
						end else if (d_sat <= -thr_w) begin
							result.move_delta = d_sat[DELTA_W-1:0];
							result.rotation   = ROT_CCW;
						end
					end
					next_state.last_position       = pos;
					next_state.last_position_known = 1'b1;
				end else begin
					// finger lifted: forget the position
					next_state.last_position       = '0;
					next_state.last_position_known = 1'b0;
				end
			end else if (!is_benign) begin
				result.rearm_request = 1'b1;
			end
		end
	end

endmodule

[design/click_wheel_packet_decoder.sv]
// top level of the click wheel packet decoder: input register, decode, result register
// Takes one poll word per cycle and gives one result word per poll, valid once the poll
// has passed the input register and the result register, each holding one word, so a new
// poll is taken every cycle while the result side keeps taking. Each poll reports the
// hold line and the five buttons (retained from the last button packet when no new one
// arrives), and for a button packet the touch flag, the position and a wrapped signed
// delta against the last touched position with a direction once its size reaches
// move_threshold. Unrecognized words set rearm_request. Configuration writes take effect
// on the next poll decoded and are meant to happen while no poll is in flight.
module click_wheel_packet_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	// hold_switch_low[0], data_ready[1], raw_word[33:2], zero[39:34]
	input  logic [cwpd_pkg::IN_W-1:0]     s_tdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// packet_valid[0], select_pressed[1], right_pressed[2], left_pressed[3],
	// play_pressed[4], menu_pressed[5], hold_active[6], finger_on[7],
	// touch_pos[14:8], move_delta[21:15], rotation[23:22], rearm_request[24],
	// zero[31:25]
	output logic [cwpd_pkg::OUT_W-1:0]    m_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic                          cfg_we,
	input  logic                          cfg_addr,
	input  logic [cwpd_pkg::CFG_W-1:0]    cfg_data
);
	import cwpd_pkg::*;

	logic               valid_s1;
	poll_t              poll_s1;
	logic               valid_s2;
	result_t            result_s2;
	wheel_state_t       state_q;
	wheel_state_t       next_state;
	result_t            result;
	logic [STEPS_W-1:0] wheel_steps_q;
	logic [THR_W-1:0]   move_threshold_q;
	logic               advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_steps_q    <= STEPS_RESET;
			move_threshold_q <= THR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_WHEEL_STEPS:    wheel_steps_q    <= cfg_data;
				REG_MOVE_THRESHOLD: move_threshold_q <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= next_state;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			poll_s1.hold_switch_low <= s_tdata[0];
			poll_s1.data_ready      <= s_tdata[1];
			poll_s1.raw_word        <= s_tdata[33:2];
		end
		if (advance)
			result_s2 <= result;
	end

	cwpd_decode u_decode (
		.poll           (poll_s1),
		.state          (state_q),
		.wheel_steps    (wheel_steps_q),
		.move_threshold (move_threshold_q),
		.result         (result),
		.next_state     (next_state)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'b0000000,
	                   result_s2.rearm_request,
	                   result_s2.rotation,
	                   result_s2.move_delta,
	                   result_s2.touch_pos,
	                   result_s2.finger_on,
	                   result_s2.hold_active,
	                   result_s2.menu_pressed,
	                   result_s2.play_pressed,
	                   result_s2.left_pressed,
	                   result_s2.right_pressed,
	                   result_s2.select_pressed,
	                   result_s2.packet_valid};

endmodule

[sim/click_wheel_packet_decoder_tb.sv]
// testbench for the click wheel packet decoder: random and directed polls, scoreboard check
`timescale 1ns / 100ps

module click_wheel_packet_decoder_tb;
	import cwpd_pkg::*;

	class wheel_report_scoreboard;
		logic [STEPS_W-1:0] wheel_steps;
		logic [THR_W-1:0]   move_threshold;
		logic [POS_W-1:0]   last_pos;
		logic               pos_known;
		logic [BTN_W-1:0]   held_buttons;
		result_t            expected_reports[$];
		int                 errors;
		int                 polls;
		int                 packets;
		int                 rotations;
		int                 rearms;
		int                 reports_checked;

		function new();
			wheel_steps = STEPS_RESET;
			move_threshold = THR_RESET;
			last_pos = '0;
			pos_known = 1'b0;
			held_buttons = '0;
		endfunction

		function void set_registers(int steps, int thr);
			wheel_steps = steps[STEPS_W-1:0];
			move_threshold = thr[THR_W-1:0];
		endfunction

		function result_t predict_report(poll_t p);
			result_t r;
			int d;
			int steps;
			int half;
			int thr;
			logic [POS_W-1:0] pos;
			r = '0;
			r.hold_active = ~p.hold_switch_low;
			if (p.data_ready) begin
				if ((p.raw_word & PKT_MASK) == PKT_BUTTONS) begin
					held_buttons = p.raw_word[12:8];
					r.packet_valid = 1'b1;
					if (p.raw_word[TOUCH_BIT]) begin
						pos = p.raw_word[22:16];
						r.finger_on = 1'b1;
						r.touch_pos = pos;
						if (pos_known) begin
							steps = int'(wheel_steps);
							half = steps / 2;
							thr = (move_threshold == '0) ? 1 : int'(move_threshold);
							d = int'(pos) - int'(last_pos);
							if (d < -half)
								d += steps;
							if (d > half)
								d -= steps;
							// a single wrap can still leave the delta outside the field
							if (d > 63)
								d = 63;
							if (d < -64)
								d = -64;
							if (d >= thr) begin
								r.move_delta = d[DELTA_W-1:0];
								r.rotation = ROT_CW;
							end else if (d <= -thr) begin
								r.move_delta = d[DELTA_W-1:0];
								r.rotation = ROT_CCW;
							end
						end
						last_pos = pos;
						pos_known = 1'b1;
					end else begin
						last_pos = '0;
						pos_known = 1'b0;
					end
				end else if ((p.raw_word & PKT_MASK) != PKT_BENIGN && p.raw_word != WORD_IDLE) begin
					r.rearm_request = 1'b1;
				end
			end
			// buttons always come from the retained set, updated above by a packet
			{r.menu_pressed, r.play_pressed, r.left_pressed, r.right_pressed,
				r.select_pressed} = held_buttons;
			return r;
		endfunction

		function void note_poll(poll_t p);
			result_t r;
			r = predict_report(p);
			expected_reports.push_back(r);
			polls++;
			if (r.packet_valid)
				packets++;
			if (r.rotation != ROT_NONE)
				rotations++;
			if (r.rearm_request)
				rearms++;
		endfunction

		function void compare_field(string name, int expv, int actv);
			if (expv != actv) begin
				errors++;
				$display("%0t: %s expected %0d, got %0d", $time, name, expv, actv);
			end
		endfunction

		function void check_report(logic [OUT_W-1:0] w);
			result_t e;
			if (expected_reports.size() == 0) begin
				errors++;
				$display("%0t: unexpected report word %h, nothing expected", $time, w);
				return;
			end
			e = expected_reports.pop_front();
			reports_checked++;
			compare_field("packet_valid", int'(e.packet_valid), int'(w[0]));
			compare_field("select_pressed", int'(e.select_pressed), int'(w[1]));
			compare_field("right_pressed", int'(e.right_pressed), int'(w[2]));
			compare_field("left_pressed", int'(e.left_pressed), int'(w[3]));
			compare_field("play_pressed", int'(e.play_pressed), int'(w[4]));
			compare_field("menu_pressed", int'(e.menu_pressed), int'(w[5]));
			compare_field("hold_active", int'(e.hold_active), int'(w[6]));
			compare_field("finger_on", int'(e.finger_on), int'(w[7]));
			compare_field("touch_pos", int'(e.touch_pos), int'(w[14:8]));
			compare_field("move_delta", int'(e.move_delta), int'($signed(w[21:15])));
			compare_field("rotation", int'(e.rotation), int'(w[23:22]));
			compare_field("rearm_request", int'(e.rearm_request), int'(w[24]));
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_addr = REG_WHEEL_STEPS;
	logic [CFG_W-1:0]  cfg_data = '0;

	wheel_report_scoreboard reports;
	int burst_left;
	bit sender_steady;
	int cur_thr = int'(THR_RESET);
	int walk_pos;
	logic [BTN_W-1:0] cur_buttons = '0;
	int settings_used = 1;
	bit long_stall_done;

	click_wheel_packet_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("[click_wheel_packet_decoder] ERROR");
		$finish;
	end

	// button packet with random filler in the bits the decoder ignores
	function automatic logic [31:0] button_word(bit touch, int pos, logic [BTN_W-1:0] btn);
		logic [31:0] w;
		w = $urandom;
		w = (w & ~PKT_MASK) | PKT_BUTTONS;
		w[TOUCH_BIT] = touch;
		w[22:16] = pos[6:0];
		w[12:8] = btn;
		return w;
	endfunction

	task automatic send_poll(input bit hold_low, input bit ready, input logic [31:0] raw);
		poll_t p;
		int gap;
		if (burst_left == 0) begin
			gap = sender_steady ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		p.hold_switch_low = hold_low;
		p.data_ready = ready;
		p.raw_word = raw;
		s_tdata <= {6'b0, raw, ready, hold_low};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		reports.note_poll(p);
		burst_left--;
	endtask

	task automatic send_touch(input int pos, input logic [BTN_W-1:0] btn);
		send_poll(1'b1, 1'b1, button_word(1'b1, pos, btn));
	endtask

	// drain every outstanding report, then let the pipeline settle
	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (reports.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_registers(input int steps, input int thr);
		settle();
		cfg_we <= 1'b1;
		cfg_addr <= REG_WHEEL_STEPS;
		cfg_data <= steps[CFG_W-1:0];
		@(posedge clk);
		cfg_addr <= REG_MOVE_THRESHOLD;
		cfg_data <= thr[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		reports.set_registers(steps, thr);
		cur_thr = thr;
		settings_used++;
	endtask

	task automatic run_random(input int n, input bit steady);
		int k;
		int span;
		int b;
		bit hold_low;
		logic [31:0] w;
		sender_steady = steady;
		span = cur_thr + 4;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			hold_low = ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 3) == 0)
				cur_buttons = BTN_W'($urandom_range(0, 31));
			if (k < 60) begin
				// mostly a finger sliding around the last position
				if ($urandom_range(0, 9) == 0)
					walk_pos = $urandom_range(0, 127);
				else
					walk_pos = (walk_pos + $urandom_range(0, 2 * span) - span) & 127;
				send_poll(hold_low, 1'b1, button_word(1'b1, walk_pos, cur_buttons));
			end else if (k < 70) begin
				send_poll(hold_low, 1'b1, button_word(1'b0, $urandom_range(0, 127), cur_buttons));
			end else if (k < 80) begin
				send_poll(hold_low, 1'b0, $urandom);
			end else if (k < 85) begin
				w = $urandom;
				send_poll(hold_low, 1'b1, (w & ~PKT_MASK) | PKT_BENIGN);
			end else if (k < 88) begin
				send_poll(hold_low, 1'b1, WORD_IDLE);
			end else if (k < 94) begin
				// button packet with one marker bit flipped
				b = $urandom_range(0, 8);
				w = button_word(1'($urandom_range(0, 1)), walk_pos, cur_buttons);
				w[(b == 8) ? 31 : b] = ~w[(b == 8) ? 31 : b];
				send_poll(hold_low, 1'b1, w);
			end else begin
				send_poll(hold_low, 1'b1, $urandom);
			end
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			reports.check_report(m_tdata);
	end

	// receiver: changing stall pattern, plus one long hold-off
	initial begin
		int rx_mode;
		int cyc;
		wait (arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 50 == 0)
				rx_mode = $urandom_range(0, 3);
			if (!long_stall_done && reports != null && reports.reports_checked >= 250) begin
				long_stall_done = 1'b1;
				m_tready <= 1'b0;
				repeat (80) @(posedge clk);
			end else begin
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= (cyc % 4 != 0);
					default: m_tready <= ($urandom_range(0, 99) < 85);
				endcase
			end
		end
	end

	initial begin
		reports = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed polls under reset register values (96 steps, threshold 2)
		sender_steady = 1'b0;
		send_poll(1'b0, 1'b0, $urandom);
		send_touch(0, 5'h1f);
		send_touch(1, 5'h1f);
		send_touch(3, 5'h01);
		send_touch(1, 5'h02);
		send_touch(95, 5'h04);
		send_touch(1, 5'h08);
		send_touch(127, 5'h10);
		send_touch(0, 5'h00);
		send_poll(1'b1, 1'b1, button_word(1'b0, 0, 5'h00));
		send_touch(50, 5'h15);
		send_poll(1'b0, 1'b1, PKT_BENIGN);
		send_poll(1'b1, 1'b1, WORD_IDLE);
		send_poll(1'b1, 1'b1, 32'h1234_5678);
		send_poll(1'b1, 1'b1, PKT_BUTTONS | 32'h1);
		send_poll(1'b1, 1'b1, PKT_BUTTONS & ~PKT_MASK | 32'h1a);
		send_poll(1'b1, 1'b0, $urandom);
		send_poll(1'b0, 1'b1, 32'hffff_ff1a);
		send_poll(1'b1, 1'b1, PKT_BUTTONS);

		apply_registers(127, 1);
		run_random(75, 1'b0);

		// small wheel: wrapped delta still saturates at the field limits
		apply_registers(4, 48);
		send_poll(1'b1, 1'b1, button_word(1'b0, 0, 5'h00));
		send_touch(0, 5'h00);
		send_touch(127, 5'h00);
		send_touch(0, 5'h00);
		run_random(72, 1'b0);

		// threshold of zero behaves as one
		apply_registers(4, 0);
		send_touch(2, 5'h0a);
		send_touch(2, 5'h0a);
		send_touch(3, 5'h0a);
		run_random(72, 1'b1);

		apply_registers(64, 63);
		run_random(75, 1'b0);
		apply_registers(5, 3);
		run_random(75, 1'b0);
		apply_registers(96, 2);
		run_random(75, 1'b1);
		repeat (2) begin
			apply_registers($urandom_range(4, 127), $urandom_range(1, 48));
			run_random(75, 1'b0);
		end

		settle();
		repeat (8) @(posedge clk);
		$display("covered %0d polls over %0d register settings: %0d button packets,",
			reports.polls, settings_used, reports.packets);
		$display("%0d rotation steps, %0d rearm requests, one long output stall",
			reports.rotations, reports.rearms);
		if (reports.errors == 0 && reports.pending() == 0)
			$display("[click_wheel_packet_decoder] OK");
		else
			$display("[click_wheel_packet_decoder] ERROR");
		$finish;
	end

endmodule
